/* rtl/ca2d_pkg.sv */
// Shared types and constants of the toroidal cellular automaton block.
package ca2d_pkg;

    localparam int SIDE_DEF     = 8;
    localparam int MAX_ROWS_OUT = 8;
    localparam int RULE_W       = 32;
    localparam int MODE_W       = 2;
    localparam int ROW_IDX_W    = 3;
    localparam int ROW_CELLS_W  = 8;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [RULE_W-1:0] RULE_RESET = 32'h6E6E_6E6E;

    localparam logic [MODE_W-1:0] MODE_SEED  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STEP  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_EMIT  = 2'd3;

    typedef enum logic [1:0] {
        OP_SEED,
        OP_WRITE,
        OP_STEP,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op                    op;
        logic [ROW_IDX_W-1:0]   row_index;
        logic [ROW_CELLS_W-1:0] row_cells;
    } t_cmd;

endpackage

/* rtl/ca2d_if.sv */
// Request channel interfaces: input commands, emitted rows, rule writes.
interface ca2d_in_if import ca2d_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [MODE_W-1:0]      mode;
    logic [ROW_IDX_W-1:0]   row_index;
    logic [ROW_CELLS_W-1:0] row_cells;

    modport source (output valid, output mode, output row_index, output row_cells,
                    input ready);
    modport sink   (input valid, input mode, input row_index, input row_cells,
                    output ready);
endinterface

interface ca2d_out_if import ca2d_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [ROW_IDX_W-1:0]   out_row_index;
    logic [ROW_CELLS_W-1:0] out_row_cells;
    logic                   last_row;

    modport source (output valid, output out_row_index, output out_row_cells,
                    output last_row, input ready);
    modport sink   (input valid, input out_row_index, input out_row_cells,
                    input last_row, output ready);
endinterface

interface ca2d_cfg_if import ca2d_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [RULE_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/ca2d_front.sv */
// Front end: accepts requests, decodes them into commands, queues them.
module ca2d_front import ca2d_pkg::*; #(
    parameter int SIDE = SIDE_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ca2d_in_if.sink i_in,
    output logic   o_cmd_valid,
    output t_cmd   o_cmd,
    input  logic   i_cmd_ready
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_cmd             r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    t_cmd dec_cmd;
    logic dec_keep;
    logic push, pop;

    always_comb begin
        dec_cmd.row_index = i_in.row_index;
        dec_cmd.row_cells = i_in.row_cells;
        dec_keep          = 1'b1;
        case (i_in.mode)
            MODE_SEED:  dec_cmd.op = OP_SEED;
            MODE_WRITE: begin
                dec_cmd.op = OP_WRITE;
                // rows outside the grid are dropped here
                dec_keep   = (int'(i_in.row_index) < SIDE);
            end
            MODE_STEP:  dec_cmd.op = OP_STEP;
            MODE_EMIT:  dec_cmd.op = OP_EMIT;
            default:    dec_cmd.op = OP_EMIT;
        endcase
    end

    assign i_in.ready  = (int'(r_count) < QUEUE_DEPTH);
    assign push        = i_in.valid && i_in.ready && dec_keep;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= dec_cmd;
        end
    end

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not rise on push");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (!pop && o_cmd_valid == 1'b0))
        else $error("pop from empty queue");

endmodule

/* rtl/ca2d_back.sv */
// Back end: grid ring of rows, per-row rule update and output register.
module ca2d_back import ca2d_pkg::*; #(
    parameter int SIDE = SIDE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_cmd_ready,
    input  logic [RULE_W-1:0] i_rule,
    ca2d_out_if.source        o_out
);

    localparam int CNT_W    = $clog2(SIDE);
    localparam int NOUT     = (SIDE < MAX_ROWS_OUT) ? SIDE : MAX_ROWS_OUT;
    localparam int SEED_IDX = (SIDE * SIDE) / 2;
    localparam int SEED_ROW = (SEED_IDX / SIDE) % SIDE;
    localparam int SEED_COL = SEED_IDX % SIDE;
    localparam logic [SIDE-1:0] SEED_BITS = SIDE'(1) << SEED_COL;

    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    t_state                 r_state, n_state;
    logic [SIDE-1:0]        r_ring [SIDE];
    logic [SIDE-1:0]        n_ring [SIDE];
    logic [SIDE-1:0]        r_prev, n_prev;
    logic [SIDE-1:0]        r_row0_old, n_row0_old;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_step, n_step;
    logic                   r_out_valid, n_out_valid;
    logic [ROW_IDX_W-1:0]   r_out_idx, n_out_idx;
    logic [ROW_CELLS_W-1:0] r_out_cells, n_out_cells;
    logic                   r_out_last, n_out_last;

    logic [SIDE-1:0] row_cur, row_dn, row_new;
    logic            is_last, emit_now, can_load, advance;

    assign row_cur  = r_ring[0];
    assign is_last  = (r_cnt == CNT_W'(SIDE - 1));
    assign row_dn   = is_last ? r_row0_old : r_ring[1];
    assign emit_now = (int'(r_cnt) < NOUT);
    assign can_load = !r_out_valid || o_out.ready;
    assign advance  = (r_state == ST_RUN) && (can_load || !emit_now);

    // rule index: {up, down, left, right, self}
    always_comb begin
        for (int x = 0; x < SIDE; x++) begin
            row_new[x] = i_rule[{r_prev[x], row_dn[x], row_cur[(x + SIDE - 1) % SIDE],
                                 row_cur[(x + 1) % SIDE], row_cur[x]}];
        end
    end

    assign o_cmd_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_ring      = r_ring;
        n_prev      = r_prev;
        n_row0_old  = r_row0_old;
        n_cnt       = r_cnt;
        n_step      = r_step;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_idx   = r_out_idx;
        n_out_cells = r_out_cells;
        n_out_last  = r_out_last;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        OP_SEED: begin
                            for (int i = 0; i < SIDE; i++) begin
                                n_ring[i] = (i == SEED_ROW) ? SEED_BITS : '0;
                            end
                        end
                        OP_WRITE: begin
                            for (int i = 0; i < SIDE; i++) begin
                                if (int'(i_cmd.row_index) == i) begin
                                    n_ring[i] = SIDE'(i_cmd.row_cells);
                                end
                            end
                        end
                        OP_STEP, OP_EMIT: begin
                            n_step     = (i_cmd.op == OP_STEP);
                            n_cnt      = '0;
                            n_row0_old = r_ring[0];
                            n_prev     = r_ring[SIDE-1];
                            n_state    = ST_RUN;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RUN: begin
                if (advance) begin
                    for (int i = 0; i < SIDE - 1; i++) begin
                        n_ring[i] = r_ring[i+1];
                    end
                    n_ring[SIDE-1] = r_step ? row_new : row_cur;
                    n_prev         = row_cur;
                    if (emit_now) begin
                        n_out_valid = 1'b1;
                        n_out_idx   = ROW_IDX_W'(r_cnt);
                        n_out_cells = ROW_CELLS_W'(r_step ? row_new : row_cur);
                        n_out_last  = (int'(r_cnt) == NOUT - 1);
                    end
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_step      <= 1'b0;
            for (int i = 0; i < SIDE; i++) begin
                r_ring[i] <= (i == SEED_ROW) ? SEED_BITS : '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_step      <= n_step;
            r_ring      <= n_ring;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev      <= n_prev;
        r_row0_old  <= n_row0_old;
        r_out_idx   <= n_out_idx;
        r_out_cells <= n_out_cells;
        r_out_last  <= n_out_last;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_row_index = r_out_idx;
    assign o_out.out_row_cells = r_out_cells;
    assign o_out.last_row      = r_out_last;

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_out_valid && !o_out.ready && emit_now)
        |=> $stable(r_cnt))
        else $error("row counter moved under output stall");

    a_run_ends_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && n_state == ST_IDLE) |-> is_last)
        else $error("pass ended before all rows");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_out_idx == ROW_IDX_W'(NOUT - 1)))
        else $error("last row flag on wrong row");

endmodule

/* rtl/toroidal_2d_cellular_automaton_step.sv */
// Top level of the toroidal cellular automaton block.
// Seed and write requests update the ring of rows and emit nothing.
// Step and emit requests hold the back end: it loads, then the ring of rows turns once,
// one row per cycle unless an output stall holds it, and the first min(SIDE, 8) rows are
// emitted in order from the output register, after the command queue and the load.
// Reset (synchronous, active low) restores the rule table and the single-cell seed.
module toroidal_2d_cellular_automaton_step import ca2d_pkg::*; #(
    parameter int SIDE = SIDE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ca2d_in_if.sink     i_in,
    ca2d_out_if.source  o_out,
    ca2d_cfg_if.sink    i_cfg
);

    logic [RULE_W-1:0] r_rule;
    logic              cmd_valid;
    logic              cmd_ready;
    t_cmd              cmd;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule <= RULE_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_rule <= i_cfg.data;
        end
    end

    ca2d_front #(
        .SIDE (SIDE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_ready (cmd_ready)
    );

    ca2d_back #(
        .SIDE (SIDE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .i_rule      (r_rule),
        .o_out       (o_out)
    );

endmodule
